>>> hdl/thr_pkg.sv
// Shared types and constants for the TCP handshake responder.
// Used by the front end, the job queue, the back end and the top level.
package thr_pkg;

	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCntW = $clog2(QDepth + 1);

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam int unsigned FLAG_FIN_BIT   = 0;
	localparam int unsigned FLAG_SYN_BIT   = 1;
	localparam int unsigned FLAG_ACK_BIT   = 4;
	localparam logic [7:0]  FLAGS_SYN_ACK  = 8'h12;
	localparam logic [7:0]  FLAGS_ACK      = 8'h10;
	localparam logic [7:0]  FLAGS_FIN_ACK  = 8'h11;

	localparam logic [15:0] LISTEN_PORT_RESET = 16'd3000;

	localparam logic REG_LISTEN_PORT = 1'b0;
	localparam logic REG_INIT_SEQ    = 1'b1;

	typedef enum logic [1:0] {
		PH_LISTEN,
		PH_SYN_RCVD,
		PH_ESTAB,
		PH_CLOSING
	} phase_t;

	typedef enum logic [1:0] {
		JOB_SYNACK,
		JOB_ACK,
		JOB_FIN
	} job_kind_t;

	typedef struct packed {
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [3:0]  ip_header_words;
		logic [15:0] ip_total_length;
		logic [7:0]  type_of_service;
		logic [7:0]  time_to_live;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] src_tcp_port;
		logic [15:0] dst_tcp_port;
		logic [31:0] sequence_in;
		logic [15:0] offset_and_flags;
	} hdr_t;

	// One reply job; addresses and ports are still in received order.
	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] rx_src_ip;
		logic [31:0] rx_dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  tos;
		logic [7:0]  ttl;
		logic [31:0] seq;
		logic [31:0] ack;
	} job_t;

	typedef struct packed {
		logic [31:0] reply_source_address;
		logic [31:0] reply_destination_address;
		logic [15:0] reply_source_port;
		logic [15:0] reply_destination_port;
		logic [31:0] sequence_out;
		logic [31:0] acknowledge_out;
		logic [7:0]  flags_out;
		logic [15:0] identification;
		logic [15:0] tos_and_ttl;
		logic [15:0] ip_checksum;
		logic [15:0] seg_checksum;
		logic        last_of_run;
	} reply_t;

endpackage

>>> hdl/tcp_handshake_responder_unit.sv
// Top level of the TCP passive handshake responder.
// Depends on thr_pkg, thr_front, thr_queue and thr_back.
//
//  Channel  Direction  Handshake               Carries
//  s_axis   in         tvalid/tready           one received header word
//  m_axis   out        tvalid/tready, tlast    one reply header word
//  cfg      in         cfg_we (no wait)        listen_port, initial_sequence
//
// A header is taken in the cycle it is offered unless the two-entry job queue
// is full; each reply passes the queue, the checksum stage and the output register.
// The back end issues one reply per cycle while m_axis is ready, so SYN and ACK
// headers sustain one per cycle and a FIN header holds it for both of its replies.
// Reset clears the phase, the identification counter, all valid flags and
// loads listen port 3000 and server sequence 0. A stall on m_axis holds the
// output word, then the checksum stage, then fills the queue before s_axis stalls.
module tcp_handshake_responder_unit
	import thr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	// received headers
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ether_type[15:0], ip_protocol[23:16], ip_header_words[27:24],
	// ip_total_length[43:28], type_of_service[51:44], time_to_live[59:52],
	// source_address[91:60], destination_address[123:92], src_tcp_port[139:124],
	// dst_tcp_port[155:140], sequence_in[187:156], offset_and_flags[203:188],
	// zero fill[207:204]
	input  logic [207:0] s_axis_tdata,
	// replies
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// reply_source_address[31:0], reply_destination_address[63:32],
	// reply_source_port[79:64], reply_destination_port[95:80],
	// sequence_out[127:96], acknowledge_out[159:128], flags_out[167:160],
	// identification[183:168], tos_and_ttl[199:184], ip_checksum[215:200],
	// seg_checksum[231:216]
	output logic [231:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	hdr_t   hdr;
	job_t   wr_job, head;
	logic   job_push;
	logic   q_full;
	logic   job_pop;
	logic   q_valid;
	reply_t reply;
	logic   in_fire;

	// Unpack the header word, lowest field first
	assign hdr.ether_type          = s_axis_tdata[15:0];
	assign hdr.ip_protocol         = s_axis_tdata[23:16];
	assign hdr.ip_header_words     = s_axis_tdata[27:24];
	assign hdr.ip_total_length     = s_axis_tdata[43:28];
	assign hdr.type_of_service     = s_axis_tdata[51:44];
	assign hdr.time_to_live        = s_axis_tdata[59:52];
	assign hdr.source_address      = s_axis_tdata[91:60];
	assign hdr.destination_address = s_axis_tdata[123:92];
	assign hdr.src_tcp_port        = s_axis_tdata[139:124];
	assign hdr.dst_tcp_port        = s_axis_tdata[155:140];
	assign hdr.sequence_in         = s_axis_tdata[187:156];
	assign hdr.offset_and_flags    = s_axis_tdata[203:188];

	// Hold off new headers only while the queue has no room for a job
	assign s_axis_tready = !q_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	thr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.hdr       (hdr),
		.push      (job_push),
		.job       (wr_job)
	);

	thr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (job_pop),
		.valid  (q_valid),
		.head   (head)
	);

	thr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (job_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_reply (reply)
	);

	// Pack the reply word, lowest field first
	assign m_axis_tdata = {
		reply.seg_checksum,
		reply.ip_checksum,
		reply.tos_and_ttl,
		reply.identification,
		reply.flags_out,
		reply.acknowledge_out,
		reply.sequence_out,
		reply.reply_destination_port,
		reply.reply_source_port,
		reply.reply_destination_address,
		reply.reply_source_address
	};
	assign m_axis_tlast = reply.last_of_run;

endmodule

>>> hdl/thr_front.sv
// Front end: filters received headers and runs the handshake phase machine.
// Depends on thr_pkg; pushes reply jobs into thr_queue.
module thr_front
	import thr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_fire,
	input  hdr_t        hdr,
	output logic        push,
	output job_t        job
);

	phase_t      phase_q, phase_d;
	logic [15:0] listen_q;
	logic [31:0] server_seq_q;
	logic        seq_inc;
	logic        match;
	logic [7:0]  flags;
	logic [31:0] payload;
	logic [31:0] seq_plus1;
	logic [31:0] seq_plus_pay;

	assign flags = hdr.offset_and_flags[7:0];
	assign match = (hdr.ether_type == ETHERTYPE_IPV4) && (hdr.ip_protocol == PROTO_TCP)
		&& (hdr.dst_tcp_port == listen_q);

	// Payload length wraps modulo 2^32 when the header lengths exceed the total
	assign payload = {16'd0, hdr.ip_total_length}
		- {26'd0, hdr.ip_header_words, 2'b00}
		- {26'd0, hdr.offset_and_flags[15:12], 2'b00};
	assign seq_plus1    = hdr.sequence_in + 32'd1;
	assign seq_plus_pay = hdr.sequence_in + payload;

	always_comb begin
		phase_d = phase_q;
		if (in_fire && match) begin
			case (phase_q)
				PH_LISTEN: begin
					if (flags[FLAG_SYN_BIT]) phase_d = PH_SYN_RCVD;
				end
				PH_SYN_RCVD: begin
					if (flags[FLAG_ACK_BIT]) phase_d = PH_ESTAB;
				end
				PH_ESTAB: begin
					if (flags[FLAG_ACK_BIT]) phase_d = PH_CLOSING;
				end
				PH_CLOSING: begin
					if (flags[FLAG_FIN_BIT]) phase_d = PH_LISTEN;
				end
				default: phase_d = PH_LISTEN;
			endcase
		end
	end

	always_comb begin
		push          = 1'b0;
		seq_inc       = 1'b0;
		job.kind      = JOB_ACK;
		job.ack       = seq_plus1;
		job.rx_src_ip = hdr.source_address;
		job.rx_dst_ip = hdr.destination_address;
		job.src_port  = hdr.src_tcp_port;
		job.dst_port  = hdr.dst_tcp_port;
		job.tos       = hdr.type_of_service;
		job.ttl       = hdr.time_to_live;
		job.seq       = server_seq_q;
		if (in_fire && match) begin
			case (phase_q)
				PH_LISTEN: begin
					push     = flags[FLAG_SYN_BIT];
					job.kind = JOB_SYNACK;
				end
				PH_SYN_RCVD: begin
					seq_inc = flags[FLAG_ACK_BIT];
				end
				PH_ESTAB: begin
					push     = flags[FLAG_ACK_BIT];
					job.kind = JOB_ACK;
					job.ack  = seq_plus_pay;
				end
				PH_CLOSING: begin
					push     = flags[FLAG_FIN_BIT];
					job.kind = JOB_FIN;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LISTEN;
			listen_q     <= LISTEN_PORT_RESET;
			server_seq_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			if (cfg_we && cfg_index == REG_LISTEN_PORT) listen_q <= cfg_data[15:0];
			if (cfg_we && cfg_index == REG_INIT_SEQ) begin
				server_seq_q <= cfg_data;
			end else if (seq_inc) begin
				server_seq_q <= server_seq_q + 32'd1;
			end
		end
	end

endmodule

>>> hdl/thr_queue.sv
// Short job queue between the front and back ends.
// Depends on thr_pkg for the job type and depth.
module thr_queue
	import thr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  job_t  wr_job,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output job_t  head
);

	job_t             slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == QCntW'(QDepth));
	assign valid   = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/thr_back.sv
// Back end: expands jobs into replies, sums checksums, folds into the output register.
// Depends on thr_pkg; pops jobs from thr_queue.
module thr_back
	import thr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  job_t   head,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output reply_t out_reply
);

	function automatic logic [15:0] fold(input logic [19:0] s);
		logic [16:0] s1;
		logic [16:0] s2;
		s1 = {13'd0, s[19:16]} + {1'b0, s[15:0]};
		s2 = s1 + {16'd0, s1[16]};
		return ~s2[15:0];
	endfunction

	logic        half_q;
	logic [15:0] ident_q;
	logic        s1_valid_q;
	reply_t      rep_s1;
	logic [19:0] ip_sum_s1, tcp_sum_s1;
	logic        m_valid_q;
	reply_t      m_q;

	logic        m_free, s1_adv, s1_load;
	reply_t      rep;
	reply_t      rep_folded;
	logic [19:0] ip_sum, tcp_sum;

	assign m_free  = !m_valid_q || out_ready;
	assign s1_adv  = s1_valid_q && m_free;
	assign s1_load = q_valid && (!s1_valid_q || s1_adv);
	// A FIN job stays at the head until its second reply is loaded into the checksum stage
	assign pop     = s1_load && !(head.kind == JOB_FIN && !half_q);

	always_comb begin
		rep.reply_source_address      = head.rx_dst_ip;
		rep.reply_destination_address = head.rx_src_ip;
		rep.reply_source_port         = head.dst_port;
		rep.reply_destination_port    = head.src_port;
		rep.sequence_out              = head.seq;
		rep.acknowledge_out           = head.ack;
		rep.identification            = ident_q;
		rep.tos_and_ttl               = {head.tos, head.ttl};
		rep.ip_checksum               = 16'd0;
		rep.seg_checksum              = 16'd0;
		case (head.kind)
			JOB_SYNACK: begin
				rep.flags_out   = FLAGS_SYN_ACK;
				rep.last_of_run = 1'b1;
			end
			JOB_FIN: begin
				rep.flags_out   = half_q ? FLAGS_FIN_ACK : FLAGS_ACK;
				rep.last_of_run = half_q;
			end
			default: begin
				rep.flags_out   = FLAGS_ACK;
				rep.last_of_run = 1'b1;
			end
		endcase

		ip_sum = 20'h04500 + {12'd0, head.tos} + 20'd40 + {4'd0, ident_q}
			+ {4'd0, head.ttl, PROTO_TCP}
			+ {4'd0, head.rx_dst_ip[31:16]} + {4'd0, head.rx_dst_ip[15:0]}
			+ {4'd0, head.rx_src_ip[31:16]} + {4'd0, head.rx_src_ip[15:0]};

		tcp_sum = {4'd0, head.rx_dst_ip[31:16]} + {4'd0, head.rx_dst_ip[15:0]}
			+ {4'd0, head.rx_src_ip[31:16]} + {4'd0, head.rx_src_ip[15:0]}
			+ {12'd0, PROTO_TCP} + 20'd20
			+ {4'd0, head.dst_port} + {4'd0, head.src_port}
			+ {4'd0, head.seq[31:16]} + {4'd0, head.seq[15:0]}
			+ {4'd0, head.ack[31:16]} + {4'd0, head.ack[15:0]}
			+ {4'd0, 4'd5, 4'd0, rep.flags_out} + 20'h0ffff;
	end

	always_comb begin
		rep_folded              = rep_s1;
		rep_folded.ip_checksum  = fold(ip_sum_s1);
		rep_folded.seg_checksum = fold(tcp_sum_s1);
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rep_s1     <= rep;
			ip_sum_s1  <= ip_sum;
			tcp_sum_s1 <= tcp_sum;
		end
		if (s1_adv) begin
			m_q <= rep_folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= 1'b0;
			ident_q    <= 16'd0;
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s1_load) begin
				ident_q <= ident_q + 16'd1;
				half_q  <= (head.kind == JOB_FIN) && !half_q;
			end
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = m_valid_q;
	assign out_reply = m_q;

endmodule

>>> bench/tb_tcp_handshake_responder_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for tcp_handshake_responder_unit: headers in, replies checked.
// Depends on thr_pkg and the responder RTL; holds its own predictor in a scoreboard class.
module tb_tcp_handshake_responder_unit;
	import thr_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned RANDOM_WORDS   = 75;
	localparam int unsigned CLOSING_WORDS  = 90;
	localparam int unsigned HOLD_CYCLES    = 300;

	// Predicts the replies of the responder and checks the ones the block sends.
	class responder_scoreboard;
		bit [15:0]   listen_port;
		bit [31:0]   initial_sequence;
		phase_t      phase;
		bit [31:0]   server_sequence;
		bit [15:0]   ident_counter;
		int unsigned mismatches;
		reply_t      pending_replies[$];

		function new();
			reset_state();
			mismatches = 0;
		endfunction

		function void reset_state();
			listen_port      = LISTEN_PORT_RESET;
			initial_sequence = 32'd0;
			phase            = PH_LISTEN;
			server_sequence  = 32'd0;
			ident_counter    = 16'd0;
		endfunction

		function void write_reg(logic idx, bit [31:0] value);
			if (idx == REG_LISTEN_PORT) begin
				listen_port = value[15:0];
			end else begin
				// loading the initial sequence restarts the server sequence too
				initial_sequence = value;
				server_sequence  = value;
			end
		endfunction

		function bit [15:0] fold_sum(bit [31:0] s);
			s = (s >> 16) + (s & 32'h0000_ffff);
			s = s + (s >> 16);
			return ~s[15:0];
		endfunction

		// Build one reply from the received header and queue it.
		function void queue_reply(hdr_t h, bit [31:0] ack, bit [7:0] flags, bit last);
			reply_t    r;
			bit [31:0] src;
			bit [31:0] dst;
			bit [31:0] sum;
			src = h.destination_address;
			dst = h.source_address;
			r.reply_source_address      = src;
			r.reply_destination_address = dst;
			r.reply_source_port         = h.dst_tcp_port;
			r.reply_destination_port    = h.src_tcp_port;
			r.sequence_out              = server_sequence;
			r.acknowledge_out           = ack;
			r.flags_out                 = flags;
			r.identification            = ident_counter;
			r.tos_and_ttl               = {h.type_of_service, h.time_to_live};
			r.last_of_run               = last;
			// IPv4 header: version 4, IHL 5, length 40, no fragment, protocol TCP
			sum = {8'h45, h.type_of_service} + 32'd40 + ident_counter
				+ {h.time_to_live, PROTO_TCP}
				+ src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
			r.ip_checksum = fold_sum(sum);
			// pseudo-header plus a 20-byte TCP header with window 65535 and no data
			sum = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + PROTO_TCP + 32'd20
				+ h.dst_tcp_port + h.src_tcp_port
				+ server_sequence[31:16] + server_sequence[15:0]
				+ ack[31:16] + ack[15:0] + {4'd5, 4'd0, flags} + 32'h0000_ffff;
			r.seg_checksum = fold_sum(sum);
			pending_replies.push_back(r);
			ident_counter++;
		endfunction

		// Advance the handshake for one accepted header word.
		function void note_header(hdr_t h);
			bit [7:0]  flags;
			bit [31:0] payload;
			flags = h.offset_and_flags[7:0];
			if (h.ether_type != ETHERTYPE_IPV4 || h.ip_protocol != PROTO_TCP
					|| h.dst_tcp_port != listen_port)
				return;
			case (phase)
				PH_LISTEN: begin
					if (flags[FLAG_SYN_BIT]) begin
						queue_reply(h, h.sequence_in + 32'd1, FLAGS_SYN_ACK, 1'b1);
						phase = PH_SYN_RCVD;
					end
				end
				PH_SYN_RCVD: begin
					// the ACK of the SYN-ACK: silent, bump our sequence
					if (flags[FLAG_ACK_BIT]) begin
						phase = PH_ESTAB;
						server_sequence++;
					end
				end
				PH_ESTAB: begin
					if (flags[FLAG_ACK_BIT]) begin
						phase = PH_CLOSING;
						// payload may go negative; the acknowledgement simply wraps
						payload = h.ip_total_length - 4 * h.ip_header_words
							- 4 * h.offset_and_flags[15:12];
						queue_reply(h, h.sequence_in + payload, FLAGS_ACK, 1'b1);
					end
				end
				default: begin
					if (flags[FLAG_FIN_BIT]) begin
						phase = PH_LISTEN;
						queue_reply(h, h.sequence_in + 32'd1, FLAGS_ACK, 1'b0);
						queue_reply(h, h.sequence_in + 32'd1, FLAGS_FIN_ACK, 1'b1);
					end
				end
			endcase
		endfunction

		function void compare_field(string name, bit [31:0] want, bit [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				$display("%0t: reply expected none, got %h", $time, got);
				return;
			end
			want = pending_replies.pop_front();
			compare_field("reply_source_address", want.reply_source_address,
				got.reply_source_address);
			compare_field("reply_destination_address", want.reply_destination_address,
				got.reply_destination_address);
			compare_field("reply_source_port", 32'(want.reply_source_port),
				32'(got.reply_source_port));
			compare_field("reply_destination_port", 32'(want.reply_destination_port),
				32'(got.reply_destination_port));
			compare_field("sequence_out", want.sequence_out, got.sequence_out);
			compare_field("acknowledge_out", want.acknowledge_out, got.acknowledge_out);
			compare_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
			compare_field("identification", 32'(want.identification),
				32'(got.identification));
			compare_field("tos_and_ttl", 32'(want.tos_and_ttl), 32'(got.tos_and_ttl));
			compare_field("ip_checksum", 32'(want.ip_checksum), 32'(got.ip_checksum));
			compare_field("seg_checksum", 32'(want.seg_checksum), 32'(got.seg_checksum));
			compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction

		function int unsigned outstanding();
			return pending_replies.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [207:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [231:0] m_axis_tdata;
	logic         m_axis_tlast;

	responder_scoreboard sb = new();

	// idle_on, hold_cycles: shared by the sender and the sink; quiet_cycles: watchdog only
	bit          idle_on = 1'b1;
	int unsigned hold_cycles = 0;
	int unsigned quiet_cycles = 0;

	tcp_handshake_responder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Flag bit that moves the handshake on from a given phase.
	function automatic int unsigned wanted_flag(phase_t p);
		case (p)
			PH_LISTEN: return FLAG_SYN_BIT;
			PH_CLOSING: return FLAG_FIN_BIT;
			default: return FLAG_ACK_BIT;
		endcase
	endfunction

	// A frame that passes the filter, with random content elsewhere.
	function automatic hdr_t matched(bit [15:0] offset_and_flags);
		hdr_t h;
		h.ether_type          = ETHERTYPE_IPV4;
		h.ip_protocol         = PROTO_TCP;
		h.ip_header_words     = 4'($urandom);
		h.ip_total_length     = 16'($urandom);
		h.type_of_service     = 8'($urandom);
		h.time_to_live        = 8'($urandom);
		h.source_address      = $urandom;
		h.destination_address = $urandom;
		h.src_tcp_port        = 16'($urandom);
		h.dst_tcp_port        = sb.listen_port;
		h.sequence_in         = $urandom;
		h.offset_and_flags    = offset_and_flags;
		return h;
	endfunction

	// Well-formed words carry the flag the current phase waits for; the rest are
	// raw noise, frames broken in one filter field, or frames missing that flag.
	function automatic hdr_t random_header(bit well_formed);
		hdr_t        h;
		int unsigned pick;
		h    = matched(16'($urandom));
		pick = $urandom_range(0, 7);
		if (pick < 4) begin
			// plausible lengths: 20-byte headers and a modest payload
			h.ip_header_words           = 4'd5;
			h.offset_and_flags[15:12]   = 4'd5;
			h.ip_total_length           = 16'(16'd40 + $urandom_range(0, 1460));
		end
		if (well_formed) begin
			h.offset_and_flags[wanted_flag(sb.phase)] = 1'b1;
			return h;
		end
		case (pick)
			0: begin
				h.ether_type   = 16'($urandom);
				h.ip_protocol  = 8'($urandom);
				h.dst_tcp_port = 16'($urandom);
			end
			1: h.ether_type = 16'($urandom);
			2: h.ip_protocol = 8'($urandom);
			3: h.dst_tcp_port = 16'($urandom);
			default: h.offset_and_flags[wanted_flag(sb.phase)] = 1'b0;
		endcase
		return h;
	endfunction

	// Offer one header word and hold it until the block takes it.
	task automatic send_header(hdr_t h);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, h.offset_and_flags, h.sequence_in, h.dst_tcp_port,
			h.src_tcp_port, h.destination_address, h.source_address, h.time_to_live,
			h.type_of_service, h.ip_total_length, h.ip_header_words, h.ip_protocol,
			h.ether_type};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_header(h);
	endtask

	task automatic pause_sender();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every reply, then allow for words that produce none.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Random words until the requested number of well-formed ones have gone in;
	// toggle idling now and then so that quiet stretches appear as well.
	task automatic random_run(int unsigned count);
		int unsigned good;
		int unsigned sent;
		bit          wf;
		good = 0;
		sent = 0;
		while (good < count) begin
			if (sent % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			pause_sender();
			wf = ($urandom_range(0, 3) != 0);
			send_header(random_header(wf));
			if (wf)
				good++;
			sent++;
		end
	endtask

	// Every corner the handshake has: filters, out-of-phase flags, length wrap.
	task automatic directed_run();
		hdr_t h;
		h = matched(16'h5002);
		h.ether_type = 16'h86dd;
		send_header(h);
		h = matched(16'h5002);
		h.ip_protocol = 8'd17;
		send_header(h);
		h = matched(16'h5002);
		h.dst_tcp_port = sb.listen_port + 16'd1;
		send_header(h);
		// ACK with nothing open: ignored
		send_header(matched(16'h5010));
		// SYN at the top of every field; the acknowledgement wraps to zero
		h = matched(16'h5002);
		h.source_address      = 32'hffff_ffff;
		h.destination_address = 32'hffff_ffff;
		h.src_tcp_port        = 16'hffff;
		h.sequence_in         = 32'hffff_ffff;
		h.type_of_service     = 8'hff;
		h.time_to_live        = 8'hff;
		send_header(h);
		pause_sender();
		send_header(matched(16'h5001));
		send_header(matched(16'h5010));
		send_header(matched(16'h5002));
		// negative payload: no length left after two 60-byte headers
		h = matched(16'hf010);
		h.ip_header_words = 4'hf;
		h.ip_total_length = 16'd0;
		send_header(h);
		send_header(matched(16'h5010));
		send_header(matched(16'h5011));
		// second round at the bottom of every field
		h = matched(16'h0002);
		h.source_address      = 32'd0;
		h.destination_address = 32'd0;
		h.src_tcp_port        = 16'd0;
		h.sequence_in         = 32'd0;
		h.type_of_service     = 8'd0;
		h.time_to_live        = 8'd0;
		h.ip_header_words     = 4'd0;
		h.ip_total_length     = 16'd0;
		send_header(h);
		pause_sender();
		send_header(matched(16'h0010));
		// odd payload length
		h = matched(16'h5010);
		h.ip_header_words = 4'd5;
		h.ip_total_length = 16'hffff;
		send_header(h);
		send_header(matched(16'hffff));
		send_header(matched(16'h0fff));
		send_header(matched(16'h0010));
		h = matched(16'h0010);
		h.ip_header_words = 4'd0;
		h.ip_total_length = 16'd1234;
		send_header(h);
		send_header(matched(16'h5001));
	endtask

	// Reply sink: random stalls, plus one long hold-off when asked for.
	initial begin : reply_sink
		m_axis_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Check every reply word the moment it is taken.
	always @(posedge clk) begin : reply_monitor
		reply_t got;
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			got.reply_source_address      = m_axis_tdata[31:0];
			got.reply_destination_address = m_axis_tdata[63:32];
			got.reply_source_port         = m_axis_tdata[79:64];
			got.reply_destination_port    = m_axis_tdata[95:80];
			got.sequence_out              = m_axis_tdata[127:96];
			got.acknowledge_out           = m_axis_tdata[159:128];
			got.flags_out                 = m_axis_tdata[167:160];
			got.identification            = m_axis_tdata[183:168];
			got.tos_and_ttl               = m_axis_tdata[199:184];
			got.ip_checksum               = m_axis_tdata[215:200];
			got.seg_checksum              = m_axis_tdata[231:216];
			got.last_of_run               = m_axis_tlast;
			sb.check_reply(got);
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : header_sender
		int unsigned n;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_LISTEN_PORT;
		cfg_data      <= 32'd0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: port 3000, sequence 0
		directed_run();
		settle();

		// lowest port, sequence about to wrap on the first ACK
		write_reg(REG_LISTEN_PORT, 32'd0);
		write_reg(REG_INIT_SEQ, 32'hffff_ffff);
		random_run(RANDOM_WORDS);
		settle();

		// highest port; hold the reply side off while words keep coming so the
		// queue fills and the input stalls
		write_reg(REG_LISTEN_PORT, 32'h0000_ffff);
		write_reg(REG_INIT_SEQ, $urandom);
		hold_cycles = HOLD_CYCLES;
		for (n = 0; n < 40; n++)
			send_header(random_header($urandom_range(0, 3) != 0));
		random_run(RANDOM_WORDS);
		settle();

		// random port with junk in the upper data bits, sequence back at zero
		write_reg(REG_LISTEN_PORT, $urandom);
		write_reg(REG_INIT_SEQ, 32'd0);
		random_run(RANDOM_WORDS);
		settle();

		// closing stretch at full rate: whole handshakes back to back, no idling
		idle_on = 1'b0;
		for (n = 0; n < CLOSING_WORDS; n++)
			send_header(random_header(1'b1));
		settle();

		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
